// ----- hdl/b3gs_pkg.sv -----
package b3gs_pkg;

  localparam int unsigned CELL_COUNT  = 4096;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned ADDR_W      = $clog2(CELL_COUNT);

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned OPERAND_W = 32;
  localparam int unsigned RESULT_W  = 32;

  // Working width for saturation: holds a cell, an operand and their sum.
  localparam int unsigned EXT_W = ((VALUE_WIDTH > OPERAND_W) ? VALUE_WIDTH : OPERAND_W) + 1;

  localparam logic signed [EXT_W-1:0] VAL_MAX =
    {{(EXT_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] VAL_MIN =
    {{(EXT_W-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

  // Index arithmetic widths.
  localparam int unsigned OFF_W   = COORD_W;
  localparam int unsigned SIZE_W  = COORD_W + 1;
  localparam int unsigned PROD1_W = OFF_W + SIZE_W;
  localparam int unsigned PROD2_W = PROD1_W + SIZE_W;
  localparam int unsigned SUM_W   = PROD2_W + 1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = COORD_W;
  localparam int unsigned CMD_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ADD   = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MAX_X = 3'd1,
    REG_MIN_Y = 3'd2,
    REG_MAX_Y = 3'd3,
    REG_MIN_Z = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic clear;    // write zero at the clearing counter and advance it
    logic capture;  // take in a new item
    logic commit;   // write back and load the result registers
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;  // clearing counter is at the last cell
  } ctrl_status_t;

endpackage

// ----- hdl/b3gs_ram.sv -----
module b3gs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/b3gs_ctrl.sv -----
module b3gs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  b3gs_pkg::ctrl_status_t status_i,
  output b3gs_pkg::ctrl_cmd_t    cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);

  import b3gs_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OFFS,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_RD,
    ST_WB
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (status_i.clear_last) state_d = ST_IDLE;
      ST_IDLE:  if (start_i) state_d = ST_OFFS;
      ST_OFFS:  state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_RD;
      ST_RD:    state_d = ST_WB;
      ST_WB:    state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_WB);
    end
  end

  assign cmd_o.clear   = (state_q == ST_CLEAR);
  assign cmd_o.capture = (state_q == ST_IDLE) && start_i;
  assign cmd_o.commit  = (state_q == ST_WB);
  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;

endmodule

// ----- hdl/b3gs_dp.sv -----
module b3gs_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  b3gs_pkg::ctrl_cmd_t                      cmd_i,
  output b3gs_pkg::ctrl_status_t                   status_o,
  input  logic                                    cfg_we_i,
  input  logic [b3gs_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [b3gs_pkg::CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic [b3gs_pkg::CMD_W-1:0]              command_i,
  input  logic signed [b3gs_pkg::COORD_W-1:0]     pos_x_i,
  input  logic signed [b3gs_pkg::COORD_W-1:0]     pos_y_i,
  input  logic signed [b3gs_pkg::COORD_W-1:0]     pos_z_i,
  input  logic signed [b3gs_pkg::OPERAND_W-1:0]   operand_i,
  output logic signed [b3gs_pkg::RESULT_W-1:0]    cell_value_o,
  output logic                                    range_err_o
);

  import b3gs_pkg::*;

  // Bound registers
  logic signed [COORD_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q, min_z_q, max_z_q;

  // Captured item
  logic [CMD_W-1:0]            cmd_q;
  logic signed [COORD_W-1:0]   x_q, y_q, z_q;
  logic signed [OPERAND_W-1:0] opv_q;

  // Index pipeline
  logic               in0_q, in1_q, in2_q;
  logic [OFF_W-1:0]   ox_q, oy_q, oz0_q, oz1_q, oz2_q;
  logic [SIZE_W-1:0]  sy_q, sz0_q, sz1_q;
  logic [PROD1_W-1:0] p1_q, p2_q, p2b_q;
  logic [PROD2_W-1:0] p3_q;
  logic [SUM_W-1:0]   sum_d;
  logic [ADDR_W-1:0]  idx_q;
  logic               err_q;

  // Clearing sweep
  logic [ADDR_W-1:0] clr_q;

  // Write-back
  logic [VALUE_WIDTH-1:0]   rdata;
  logic signed [EXT_W-1:0]  old_ext, op_ext, sum_ext, new_ext;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [VALUE_WIDTH-1:0]   ram_wdata;
  logic signed [RESULT_W-1:0] cell_value_q;
  logic                     oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0;
      max_x_q <= COORD_W'(15);
      min_y_q <= '0;
      max_y_q <= COORD_W'(15);
      min_z_q <= '0;
      max_z_q <= COORD_W'(15);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_X: min_x_q <= cfg_wdata_i;
        REG_MAX_X: max_x_q <= cfg_wdata_i;
        REG_MIN_Y: min_y_q <= cfg_wdata_i;
        REG_MAX_Y: max_y_q <= cfg_wdata_i;
        REG_MIN_Z: min_z_q <= cfg_wdata_i;
        REG_MAX_Z: max_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear && !status_o.clear_last) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  assign status_o.clear_last = (clr_q == ADDR_W'(CELL_COUNT - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= command_i;
      x_q   <= pos_x_i;
      y_q   <= pos_y_i;
      z_q   <= pos_z_i;
      opv_q <= operand_i;
    end
  end

  // The index pipeline runs every cycle; the controller steps through it once the
  // captured item is stable, so each stage holds this item's values when read.
  always_ff @(posedge clk_i) begin
    in0_q <= (x_q >= min_x_q) && (x_q <= max_x_q) &&
             (y_q >= min_y_q) && (y_q <= max_y_q) &&
             (z_q >= min_z_q) && (z_q <= max_z_q);
    ox_q  <= OFF_W'(x_q - min_x_q);
    oy_q  <= OFF_W'(y_q - min_y_q);
    oz0_q <= OFF_W'(z_q - min_z_q);
    sy_q  <= SIZE_W'(max_y_q) - SIZE_W'(min_y_q) + SIZE_W'(1);
    sz0_q <= SIZE_W'(max_z_q) - SIZE_W'(min_z_q) + SIZE_W'(1);

    in1_q <= in0_q;
    p1_q  <= PROD1_W'(ox_q) * PROD1_W'(sy_q);
    p2_q  <= PROD1_W'(oy_q) * PROD1_W'(sz0_q);
    sz1_q <= sz0_q;
    oz1_q <= oz0_q;

    in2_q <= in1_q;
    p3_q  <= PROD2_W'(p1_q) * PROD2_W'(sz1_q);
    p2b_q <= p2_q;
    oz2_q <= oz1_q;

    err_q <= !in2_q || (sum_d >= SUM_W'(CELL_COUNT));
    idx_q <= sum_d[ADDR_W-1:0];
  end

  assign sum_d = SUM_W'(p3_q) + SUM_W'(p2b_q) + SUM_W'(oz2_q);

  assign old_ext = EXT_W'(signed'(rdata));
  assign op_ext  = EXT_W'(opv_q);
  assign sum_ext = old_ext + op_ext;

  always_comb begin
    new_ext = old_ext;
    unique case (cmd_q)
      CMD_WRITE: begin
        if (op_ext > VAL_MAX) begin
          new_ext = VAL_MAX;
        end else if (op_ext < VAL_MIN) begin
          new_ext = VAL_MIN;
        end else begin
          new_ext = op_ext;
        end
      end
      CMD_ADD: begin
        if (sum_ext > VAL_MAX) begin
          new_ext = VAL_MAX;
        end else if (sum_ext < VAL_MIN) begin
          new_ext = VAL_MIN;
        end else begin
          new_ext = sum_ext;
        end
      end
      default: new_ext = old_ext;
    endcase
  end

  assign ram_we    = cmd_i.clear || (cmd_i.commit && !err_q);
  assign ram_waddr = cmd_i.clear ? clr_q : idx_q;
  assign ram_wdata = cmd_i.clear ? '0 : new_ext[VALUE_WIDTH-1:0];

  b3gs_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(CELL_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      cell_value_q <= err_q ? '0 : new_ext[RESULT_W-1:0];
      oor_q        <= err_q;
    end
  end

  assign cell_value_o = cell_value_q;
  assign range_err_o  = oor_q;

endmodule

// ----- hdl/bounded_3d_grid_store_unit.sv -----
// Channel   Handshake          Payload
// command   start_i / busy_o   command_i, pos_x_i, pos_y_i, pos_z_i, operand_i
// result    done_o (strobe)    cell_value_o, range_err_o
// config    cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// An item is accepted when start_i is high and busy_o is low. Its result is strobed
// on done_o once the item has passed the index path (offsets, two registered multiply
// stages, add and compare), the registered RAM read and the write-back; busy_o is
// already low in that strobe cycle, so a new item can be taken in it, but not while one
// is in flight. After reset all 4096 cells are swept to zero at one cell per cycle,
// busy_o high throughout. done_o is high for a single cycle; the receiver cannot stall.
module bounded_3d_grid_store_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [b3gs_pkg::CMD_W-1:0]            command_i,
  input  logic signed [b3gs_pkg::COORD_W-1:0]   pos_x_i,
  input  logic signed [b3gs_pkg::COORD_W-1:0]   pos_y_i,
  input  logic signed [b3gs_pkg::COORD_W-1:0]   pos_z_i,
  input  logic signed [b3gs_pkg::OPERAND_W-1:0] operand_i,
  output logic                                  done_o,
  output logic signed [b3gs_pkg::RESULT_W-1:0]  cell_value_o,
  output logic                                  range_err_o,
  input  logic                                  cfg_we_i,
  input  logic [b3gs_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [b3gs_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  import b3gs_pkg::*;

  ctrl_cmd_t    ctrl_cmd;
  ctrl_status_t ctrl_status;

  b3gs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .status_i(ctrl_status),
    .cmd_o   (ctrl_cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  b3gs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .status_o      (ctrl_status),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .command_i     (command_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .operand_i     (operand_i),
    .cell_value_o  (cell_value_o),
    .range_err_o   (range_err_o)
  );

endmodule

// ----- tb/bounded_3d_grid_store_unit_tb.sv -----
module bounded_3d_grid_store_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b3gs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [VALUE_WIDTH-1:0] CELL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_WIDTH-1:0] CELL_MIN = 32'sh8000_0000;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic signed [RESULT_W-1:0] value;
    logic                       oor;
  } cell_outcome_t;

  class grid_scoreboard;
    logic signed [VALUE_WIDTH-1:0] cells [CELL_COUNT];
    logic signed [COORD_W-1:0]     lo [3];
    logic signed [COORD_W-1:0]     hi [3];
    cell_outcome_t                 pending [$];
    int                            errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      lo = '{0, 0, 0};
      hi = '{15, 15, 15};
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MIN_X: lo[0] = data;
        REG_MAX_X: hi[0] = data;
        REG_MIN_Y: lo[1] = data;
        REG_MAX_Y: hi[1] = data;
        REG_MIN_Z: lo[2] = data;
        REG_MAX_Z: hi[2] = data;
        default: ;
      endcase
    endfunction

    function void note_item(logic [CMD_W-1:0] cmd, logic signed [COORD_W-1:0] px,
                            logic signed [COORD_W-1:0] py, logic signed [COORD_W-1:0] pz,
                            logic signed [OPERAND_W-1:0] opv);
      longint                        pt [3];
      longint                        span_y, span_z, cell_idx;
      logic signed [VALUE_WIDTH:0]   total;
      logic signed [VALUE_WIDTH-1:0] v;
      bit                            in_box;
      cell_outcome_t                 o;
      int                            a;
      pt[0] = px;
      pt[1] = py;
      pt[2] = pz;
      in_box = 1'b1;
      for (a = 0; a < 3; a++) begin
        if (pt[a] < lo[a] || pt[a] > hi[a]) in_box = 1'b0;
      end
      cell_idx = 0;
      if (in_box) begin
        span_y = hi[1] - lo[1] + 1;
        span_z = hi[2] - lo[2] + 1;
        cell_idx = (pt[0] - lo[0]) * span_y * span_z + (pt[1] - lo[1]) * span_z
                   + (pt[2] - lo[2]);
        if (cell_idx >= CELL_COUNT) in_box = 1'b0;
      end
      if (!in_box) begin
        o.value = '0;
        o.oor   = 1'b1;
      end else begin
        v = cells[cell_idx];
        if (cmd == CMD_WRITE) begin
          v = opv;
        end else if (cmd == CMD_ADD) begin
          total = v + opv;
          if (total > CELL_MAX) v = CELL_MAX;
          else if (total < CELL_MIN) v = CELL_MIN;
          else v = total[VALUE_WIDTH-1:0];
        end
        cells[cell_idx] = v;
        o.value = v;
        o.oor   = 1'b0;
      end
      pending.push_back(o);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic signed [RESULT_W-1:0] value, logic oor);
      cell_outcome_t o;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending: value=%h oor=%b", value, oor));
        return;
      end
      o = pending.pop_front();
      if (value !== o.value)
        report($sformatf("cell_value %h, predicted %h", value, o.value));
      if (oor !== o.oor)
        report($sformatf("range_err %b, predicted %b", oor, o.oor));
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic [CMD_W-1:0]              command_i;
  logic signed [COORD_W-1:0]     pos_x_i;
  logic signed [COORD_W-1:0]     pos_y_i;
  logic signed [COORD_W-1:0]     pos_z_i;
  logic signed [OPERAND_W-1:0]   operand_i;
  logic                          done_o;
  logic signed [RESULT_W-1:0]    cell_value_o;
  logic                          range_err_o;
  logic                          cfg_we_i;
  logic [CFG_IDX_W-1:0]          cfg_idx_i;
  logic [CFG_DATA_W-1:0]         cfg_wdata_i;

  grid_scoreboard            sb;
  bit                        gaps_on;
  bit                        have_last;
  logic signed [COORD_W-1:0] last_pt [3];
  int                        quiet_cycles;

  bounded_3d_grid_store_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Every transfer, on either side, is seen here at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(cell_value_o, range_err_o);
      if (start_i && !busy_o) sb.note_item(command_i, pos_x_i, pos_y_i, pos_z_i, operand_i);
      if (cfg_we_i) sb.set_reg(cfg_idx_i, cfg_wdata_i);
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [COORD_W-1:0] px,
                           logic signed [COORD_W-1:0] py, logic signed [COORD_W-1:0] pz,
                           logic signed [OPERAND_W-1:0] opv);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(99) < 30) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    start_i   = 1'b1;
    command_i = cmd;
    pos_x_i   = px;
    pos_y_i   = py;
    pos_z_i   = pz;
    operand_i = opv;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Stop sending and wait until every pending cell outcome has arrived.
  task automatic drain_results();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, int data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = r;
    cfg_wdata_i = 16'(data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_box(int mnx, int mxx, int mny, int mxy, int mnz, int mxz);
    write_reg(REG_MIN_X, mnx);
    write_reg(REG_MAX_X, mxx);
    write_reg(REG_MIN_Y, mny);
    write_reg(REG_MAX_Y, mxy);
    write_reg(REG_MIN_Z, mnz);
    write_reg(REG_MAX_Z, mxz);
    have_last = 1'b0;
  endtask

  // Mostly points inside the box, kept near its low corner by cap so that the
  // row-major index stays within the store; the rest probe the faces and beyond.
  function automatic logic signed [COORD_W-1:0] pick_coord(int a, int cap);
    int lo_v, hi_v, span, r;
    lo_v = sb.lo[a];
    hi_v = sb.hi[a];
    r = $urandom_range(99);
    if (r < 8) return 16'($urandom);
    if (r < 16) return $urandom_range(1) ? 16'(lo_v - 1) : 16'(hi_v + 1);
    if (r < 20) return $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
    if (hi_v < lo_v) return 16'(lo_v + $urandom_range(0, cap));
    span = hi_v - lo_v;
    if (span > cap) span = cap;
    return 16'(lo_v + $urandom_range(0, span));
  endfunction

  task automatic run_random(int count, int cap_x, int cap_y, int cap_z);
    logic [CMD_W-1:0]            cmd;
    logic signed [COORD_W-1:0]   pt [3];
    logic signed [OPERAND_W-1:0] opv;
    int                          caps [3];
    int                          r;
    caps = '{cap_x, cap_y, cap_z};
    repeat (count) begin
      if (have_last && $urandom_range(99) < 25) begin
        pt = last_pt;
      end else begin
        for (int a = 0; a < 3; a++) pt[a] = pick_coord(a, caps[a]);
      end
      r = $urandom_range(99);
      if (r < 30) cmd = CMD_READ;
      else if (r < 60) cmd = CMD_WRITE;
      else if (r < 95) cmd = CMD_ADD;
      else cmd = CMD_UNUSED;
      r = $urandom_range(99);
      if (r < 10) begin
        opv = $urandom_range(1) ? CELL_MAX : CELL_MIN;
      end else if (r < 35) begin
        opv = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(1)) opv = -opv;
      end else begin
        opv = $urandom;
      end
      send_item(cmd, pt[0], pt[1], pt[2], opv);
      last_pt = pt;
      have_last = 1'b1;
    end
  endtask

  initial begin
    sb = new();
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    command_i   = CMD_READ;
    pos_x_i     = '0;
    pos_y_i     = '0;
    pos_z_i     = '0;
    operand_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_MIN_X;
    cfg_wdata_i = '0;
    gaps_on     = 1'b1;
    have_last   = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    // The grid is swept to zero after reset; busy stays high until it is done.
    do @(posedge clk_i); while (busy_o !== 1'b0);

    // Reset box: saturation at both ends, the unused command and points outside on each axis.
    send_item(CMD_READ, 0, 0, 0, 0);
    send_item(CMD_WRITE, 15, 15, 15, CELL_MAX);
    send_item(CMD_ADD, 15, 15, 15, 1);
    send_item(CMD_WRITE, 0, 0, 0, CELL_MIN);
    send_item(CMD_ADD, 0, 0, 0, -1);
    send_item(CMD_ADD, 0, 0, 0, CELL_MAX);
    send_item(CMD_UNUSED, 0, 0, 0, 12345);
    send_item(CMD_WRITE, -1, 0, 0, 5);
    send_item(CMD_WRITE, 16, 15, 15, 5);
    send_item(CMD_READ, 0, -32768, 0, 0);
    send_item(CMD_ADD, 0, 0, 32767, 7);
    send_item(CMD_WRITE, 3, 7, 11, 32'sh0001_8000);
    send_item(CMD_ADD, 3, 7, 11, 32'sh0000_8000);
    send_item(CMD_READ, 15, 15, 15, 0);

    // A box larger than the store: the last cell and the first index past it.
    drain_results();
    set_box(0, 31, 0, 31, 0, 31);
    send_item(CMD_WRITE, 3, 31, 31, -2);
    send_item(CMD_WRITE, 4, 0, 0, 9);
    send_item(CMD_READ, 3, 31, 31, 0);

    drain_results();
    set_box(5, 4, 0, 15, 0, 15);
    send_item(CMD_READ, 5, 0, 0, 0);

    drain_results();
    set_box(-32768, 32767, -32768, 32767, -32768, 32767);
    send_item(CMD_WRITE, -32768, -32768, -32768, 42);
    send_item(CMD_ADD, -32768, -32768, -32768 + 4095, -3);
    send_item(CMD_READ, -32768, -32768, -32768 + 4096, 0);
    send_item(CMD_READ, 32767, 32767, 32767, 0);

    drain_results();
    set_box(0, 15, 0, 15, 0, 15);
    run_random(100, 15, 15, 15);
    drain_results();
    run_random(100, 15, 15, 15);

    // This box fills the store exactly; sent back to back with no gaps.
    drain_results();
    set_box(-4, 3, -8, 7, 100, 131);
    gaps_on = 1'b0;
    run_random(200, 7, 15, 31);
    gaps_on = 1'b1;

    drain_results();
    set_box(0, 31, 0, 31, 0, 31);
    run_random(150, 4, 31, 31);

    drain_results();
    set_box(-32768, 32767, -32768, 32767, -32768, 32767);
    run_random(150, 0, 0, 4095);

    drain_results();
    set_box(5, 9, -3, 3, -50, 49);
    run_random(200, 4, 6, 99);

    drain_results();
    set_box(10, 20, 7, 2, 0, 15);
    run_random(60, 10, 5, 15);

    drain_results();
    set_box(32760, 32767, -32768, -32761, 0, 63);
    run_random(200, 7, 7, 63);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/b3gs_pkg.sv
hdl/b3gs_ram.sv
hdl/b3gs_ctrl.sv
hdl/b3gs_dp.sv
hdl/bounded_3d_grid_store_unit.sv
tb/bounded_3d_grid_store_unit_tb.sv
